// File: hw/rtl/olphm_pkg.sv
// Shared types and constants for the ordered linear-probe hash map.
`timescale 1ns / 1ps
`default_nettype none
package olphm_pkg;
  localparam int unsigned TableSlotsDefault = 1024;
  localparam logic [63:0] EmptyKey = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] NotFound = 32'h8000_0000;
  localparam logic [63:0] HashMul = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [9:0] FillLimitReset = 10'd512;

  typedef enum logic [1:0] {
    MODE_PUT = 2'd0,
    MODE_GET = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_PRESENT = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_RESERVED = 3'd3,
    ST_FULL = 3'd4
  } status_t;

  localparam logic [0:0] RegFillLimit = 1'b0;
endpackage
`default_nettype wire

// File: hw/rtl/ordered_linear_probe_hash_map_core.sv
// Ordered linear-probe hash map: top level with sequencer, hash unit and slot memory.
// From accept to valid result: a reserved key or unused mode goes straight to output;
// else the key is hashed, each probed slot is read and checked, and the output loaded.
// A new put probes its run twice. A remove rehashes later slots to refill the hole, moves
// each fit up and empties the last hole. One request at a time; the next is taken when
// its result is loaded. After reset a clearing pass empties all TABLE_SLOTS slots.
`timescale 1ns / 1ps
`default_nettype none
module ordered_linear_probe_hash_map_core
  import olphm_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TableSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // mode[1:0], key[65:2], value[97:66], zero fill [103:98]
  input  wire logic [103:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // result_value[31:0], status[34:32], entry_total[44:35], zero fill [47:45]
  output logic [47:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam logic [AW:0] SlotsW = (AW + 1)'(TABLE_SLOTS);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_SLOTS - 1);
  localparam int unsigned WordW = 96;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'd1,
    S_IDLE   = 14'd2,
    S_HASH   = 14'd4,
    S_LRD    = 14'd8,
    S_LCHK   = 14'd16,
    S_PRD    = 14'd32,
    S_PCHK   = 14'd64,
    S_DRD    = 14'd128,
    S_DCHK   = 14'd256,
    S_DHASH  = 14'd512,
    S_DMOVE  = 14'd1024,
    S_DEND   = 14'd2048,
    S_OUT    = 14'd4096,
    S_PEND   = 14'd8192
  } state_t;

  state_t state;
  logic [WordW-1:0] mem [TABLE_SLOTS];
  logic [WordW-1:0] rd;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic [WordW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  logic [9:0] fill_limit, entry_count;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegFillLimit) ? {22'd0, fill_limit} : 32'd0;

  logic [1:0] mode;
  logic [63:0] key, cur_key;
  logic [31:0] cur_val, res_val;
  logic [2:0] status;
  logic [AW-1:0] idx, hole, home;
  logic [AW:0] steps;
  logic [2:0] hcnt;
  logic hash_rem;   // hash run belongs to the remove scan
  logic [63:0] hprod;
  logic [63:0] hop;
  logic [9:0] cap;

  assign cap = (32'(fill_limit) > TABLE_SLOTS - 1) ? 10'(TABLE_SLOTS - 1) : fill_limit;
  assign s_tready = (state == S_IDLE);

  // Shared multiplier: 64x64 low product as three 32x32 partials over cycles.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] part;
  always_comb begin
    unique case (hcnt)
      3'd0: begin mul_a = hop[31:0]; mul_b = HashMul[31:0]; end
      3'd1: begin mul_a = hop[31:0]; mul_b = HashMul[63:32]; end
      3'd2: begin mul_a = hop[63:32]; mul_b = HashMul[31:0]; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign part = (hcnt == 3'd0) ? mul_p : {mul_p[31:0], 32'd0};

  // TABLE_SLOTS is a power of two, so the low bits of the upper word are the home slot.
  logic [AW-1:0] hash_home;
  assign hash_home = hprod[32 +: AW];

  logic [AW-1:0] idx_fwd;
  assign idx_fwd = (idx == LastIdx) ? '0 : idx + 1'b1;
  logic [63:0] rkey;
  logic [31:0] rval;
  assign rkey = rd[63:0];
  assign rval = rd[95:64];
  logic above;
  assign above = (rkey ^ 64'h8000_0000_0000_0000) > (cur_key ^ 64'h8000_0000_0000_0000);
  logic [AW-1:0] dist_hole;
  assign dist_hole = idx - hole;

  always_comb begin
    raddr = idx;
    we = 1'b0;
    waddr = idx;
    wdata = {cur_val, cur_key};
    unique case (state)
      S_CLEAR: begin we = 1'b1; wdata = {32'd0, EmptyKey}; end
      S_PCHK: we = (rkey == EmptyKey) || !above;
      S_DMOVE: begin we = 1'b1; waddr = hole; wdata = {cur_val, cur_key}; end
      S_DEND: begin we = 1'b1; waddr = hole; wdata = {32'd0, EmptyKey}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      fill_limit <= FillLimitReset;
      entry_count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == RegFillLimit) fill_limit <= pwdata[9:0];
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          idx <= idx_fwd;
          if (idx == LastIdx) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          mode <= s_tdata[1:0];
          key <= s_tdata[65:2];
          cur_key <= s_tdata[65:2];
          cur_val <= s_tdata[97:66];
          res_val <= 32'd0;
          status <= ST_DONE;
          hop <= s_tdata[65:2];
          hprod <= '0;
          hcnt <= '0;
          hash_rem <= 1'b0;
          if (s_tdata[1:0] == MODE_NONE) state <= S_OUT;
          else if (s_tdata[65:2] == EmptyKey) begin
            res_val <= NotFound; status <= ST_RESERVED; state <= S_OUT;
          end else state <= S_HASH;
        end
        S_HASH, S_DHASH: begin
          hprod <= hprod + part;
          hcnt <= hcnt + 3'd1;
          if (hcnt == 3'd3) begin
            if (hash_rem) begin
              // candidate at idx may fill the hole if home is not after the hole
              if ((idx - hash_home) >= dist_hole) begin
                cur_key <= rkey; cur_val <= rval; state <= S_DMOVE;
              end else begin
                idx <= idx_fwd; steps <= steps + 1'b1; state <= S_DRD;
              end
            end else begin
              idx <= hash_home; home <= hash_home; steps <= '0; state <= S_LRD;
            end
          end
        end
        S_LRD: state <= S_LCHK;
        S_LCHK: begin
          if (rkey == EmptyKey || steps == SlotsW) begin
            if (mode == MODE_PUT) begin
              if (entry_count >= cap) begin status <= ST_FULL; state <= S_OUT; end
              else begin idx <= home; steps <= '0; state <= S_PRD; end
            end else begin
              res_val <= NotFound; status <= ST_NOT_FOUND; state <= S_OUT;
            end
          end else if (rkey == key) begin
            res_val <= rval;
            if (mode == MODE_PUT) begin status <= ST_PRESENT; state <= S_OUT; end
            else if (mode == MODE_GET) state <= S_OUT;
            else begin
              hole <= idx; idx <= idx_fwd; steps <= '0; state <= S_DRD;
            end
          end else begin
            idx <= idx_fwd; steps <= steps + 1'b1; state <= S_LRD;
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (rkey == EmptyKey || steps == SlotsW) state <= S_PEND;
          else begin
            if (!above) begin cur_key <= rkey; cur_val <= rval; end
            idx <= idx_fwd; steps <= steps + 1'b1; state <= S_PRD;
          end
        end
        S_PEND: begin
          entry_count <= entry_count + 10'd1;
          if (entry_count + 10'd1 >= cap) status <= ST_FULL;
          state <= S_OUT;
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          if (rkey == EmptyKey || steps == SlotsW - 1'b1) state <= S_DEND;
          else begin
            hop <= rkey; hprod <= '0; hcnt <= '0; hash_rem <= 1'b1; state <= S_DHASH;
          end
        end
        S_DMOVE: begin
          hole <= idx; idx <= idx_fwd; steps <= '0; state <= S_DRD;
        end
        S_DEND: begin
          if (entry_count != 10'd0) entry_count <= entry_count - 10'd1;
          state <= S_OUT;
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tdata <= {3'd0, entry_count, status, res_val};
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: dv/ordered_linear_probe_hash_map_core_tb.sv
// Self-checking testbench for the ordered linear-probe hash map core.
`timescale 1ns / 1ps
`default_nettype none
module ordered_linear_probe_hash_map_core_tb;
  import olphm_pkg::*;

  localparam int Slots = 1024;
  localparam int StallLimit = 200000;

  typedef struct packed {
    logic [31:0] rval;
    status_t     st;
    logic [9:0]  total;
  } map_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [103:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #2 clk = ~clk;

  ordered_linear_probe_hash_map_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the table.
  logic [63:0] shadow_key [Slots];
  logic [31:0] shadow_val [Slots];
  int unsigned shadow_count;
  logic [9:0] shadow_limit;
  map_reply_t pending_replies [$];
  int errors = 0;
  int idle_pct = 15;
  int stall_cycles = 0;
  logic [63:0] used_keys [$];

  function automatic int unsigned home_slot(logic [63:0] k);
    logic [63:0] p;
    p = k * HashMul;
    return p[63:32] % Slots;
  endfunction

  function automatic int unsigned next_slot(int unsigned i);
    return (i + 1 >= Slots) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_dist(int unsigned from, int unsigned to);
    return (to + Slots - from) % Slots;
  endfunction

  function automatic int find_slot(logic [63:0] k);
    int unsigned i;
    i = home_slot(k);
    for (int n = 0; n < Slots; n++) begin
      if (shadow_key[i] == EmptyKey) return -1;
      if (shadow_key[i] == k) return i;
      i = next_slot(i);
    end
    return -1;
  endfunction

  task automatic insert_ordered(logic [63:0] k, logic [31:0] v);
    int unsigned i;
    logic [63:0] tk;
    logic [31:0] tv;
    i = home_slot(k);
    for (int n = 0; n < Slots; n++) begin
      if (shadow_key[i] == EmptyKey) begin
        shadow_key[i] = k;
        shadow_val[i] = v;
        return;
      end
      if (!($signed(shadow_key[i]) > $signed(k))) begin
        tk = shadow_key[i];
        tv = shadow_val[i];
        shadow_key[i] = k;
        shadow_val[i] = v;
        k = tk;
        v = tv;
      end
      i = next_slot(i);
    end
  endtask

  // Backward-shift deletion: pull up the first later entry allowed to sit in the hole.
  task automatic delete_at(int unsigned h);
    int unsigned j;
    bit moved;
    for (int g = 0; g < Slots; g++) begin
      j = next_slot(h);
      moved = 0;
      for (int n = 0; n + 1 < Slots; n++) begin
        if (shadow_key[j] == EmptyKey) break;
        if (ring_dist(home_slot(shadow_key[j]), j) >= ring_dist(h, j)) begin
          shadow_key[h] = shadow_key[j];
          shadow_val[h] = shadow_val[j];
          h = j;
          moved = 1;
          break;
        end
        j = next_slot(j);
      end
      if (!moved) break;
    end
    shadow_key[h] = EmptyKey;
    shadow_val[h] = '0;
  endtask

  task automatic predict_request(mode_t mode, logic [63:0] k, logic [31:0] v);
    map_reply_t r;
    int pos;
    int unsigned cap;
    cap = (shadow_limit > Slots - 1) ? Slots - 1 : shadow_limit;
    r.rval = '0;
    r.st = ST_DONE;
    if (mode != MODE_NONE && k == EmptyKey) begin
      r.rval = NotFound;
      r.st = ST_RESERVED;
    end else if (mode == MODE_PUT) begin
      pos = find_slot(k);
      if (pos >= 0) begin
        r.rval = shadow_val[pos];
        r.st = ST_PRESENT;
      end else if (shadow_count >= cap) begin
        r.st = ST_FULL;
      end else begin
        insert_ordered(k, v);
        shadow_count++;
        if (shadow_count >= cap) r.st = ST_FULL;
      end
    end else if (mode == MODE_GET || mode == MODE_REMOVE) begin
      pos = find_slot(k);
      if (pos >= 0) begin
        r.rval = shadow_val[pos];
        if (mode == MODE_REMOVE) begin
          delete_at(pos);
          if (shadow_count > 0) shadow_count--;
        end
      end else begin
        r.rval = NotFound;
        r.st = ST_NOT_FOUND;
      end
    end
    r.total = shadow_count[9:0];
    pending_replies.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // tvalid stays high after a transfer until the next item or an idle cycle replaces it.
  task automatic send_request(mode_t mode, logic [63:0] k, logic [31:0] v);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, v, k, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(mode, k, v);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_fill_limit(logic [9:0] lim);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {RegFillLimit, 2'b00};
    pwdata <= {22'($urandom_range(4194303)), lim};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_limit = lim;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (prdata !== {22'd0, lim}) report_mismatch("fill_limit readback", prdata, {22'd0, lim});
  endtask

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    if (used_keys.size() > 0 && $urandom_range(99) < 60)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    k = {$urandom, $urandom};
    if ($urandom_range(3) == 0) k = {{48{k[15]}}, k[15:0]};
    if (k == EmptyKey) k = 64'd7;
    if (used_keys.size() < 400) used_keys.push_back(k);
    return k;
  endfunction

  // Result side: random backpressure and in-order comparison.
  always @(posedge clk) begin
    map_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
        end else begin
          want = pending_replies.pop_front();
          if (m_tdata[31:0] !== want.rval) report_mismatch("result_value", m_tdata[31:0], want.rval);
          if (m_tdata[34:32] !== want.st) report_mismatch("status", m_tdata[34:32], want.st);
          if (m_tdata[44:35] !== want.total) report_mismatch("entry_total", m_tdata[44:35], want.total);
        end
      end
      m_tready <= !(idle_pct > 0 && $urandom_range(99) < idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on either side; allows for the clearing pass.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(MODE_GET, 64'd5, 32'd0);
    send_request(MODE_REMOVE, 64'd5, 32'd0);
    send_request(MODE_PUT, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_request(MODE_PUT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    send_request(MODE_PUT, 64'd0, 32'hFFFF_FFFF);
    send_request(MODE_PUT, 64'd0, 32'd1);
    send_request(MODE_PUT, EmptyKey, 32'd3);
    send_request(MODE_GET, EmptyKey, 32'd0);
    send_request(MODE_REMOVE, EmptyKey, 32'd0);
    send_request(MODE_NONE, 64'd0, 32'd9);
    send_request(MODE_NONE, EmptyKey, 32'hFFFF_FFFF);
    send_request(MODE_GET, 64'h8000_0000_0000_0000, 32'd0);
    send_request(MODE_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0);
    send_request(MODE_GET, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0);
    send_request(MODE_REMOVE, 64'd0, 32'd0);
    send_request(MODE_REMOVE, 64'h8000_0000_0000_0000, 32'd0);
  endtask

  // Keys with hash homes in slots 1020 to 1023 build long runs that exercise ordering and shifts.
  task automatic test_collisions();
    logic [63:0] ks [$];
    logic [63:0] k;
    while (ks.size() < 12) begin
      k = {$urandom, $urandom};
      if (home_slot(k) >= 1020 && k != EmptyKey) ks.push_back(k);
    end
    foreach (ks[i]) send_request(MODE_PUT, ks[i], $urandom);
    foreach (ks[i]) send_request(MODE_GET, ks[i], $urandom);
    for (int i = 0; i < 12; i += 2) send_request(MODE_REMOVE, ks[i], $urandom);
    foreach (ks[i]) send_request(MODE_GET, ks[i], 0);
    for (int i = 1; i < 12; i += 2) send_request(MODE_REMOVE, ks[i], 0);
  endtask

  task automatic test_fill_limit();
    write_fill_limit(10'd1);
    send_request(MODE_PUT, 64'd11, 32'd1);
    send_request(MODE_PUT, 64'd12, 32'd2);
    send_request(MODE_PUT, 64'd11, 32'd3);
    send_request(MODE_REMOVE, 64'd11, 0);
    write_fill_limit(10'd0);
    send_request(MODE_PUT, 64'd13, 32'd4);
    write_fill_limit(10'd6);
    for (int i = 0; i < 10; i++) send_request(MODE_PUT, {$urandom, $urandom}, $urandom);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) send_request(MODE_PUT, pick_key(), $urandom);
      else if (r < 70) send_request(MODE_GET, pick_key(), $urandom);
      else if (r < 95) send_request(MODE_REMOVE, pick_key(), $urandom);
      else if (r < 98) send_request(MODE_NONE, pick_key(), $urandom);
      else send_request(mode_t'($urandom_range(2)), EmptyKey, $urandom);
    end
  endtask

  task automatic test_saturation();
    write_fill_limit(10'd1023);
    idle_pct = 0;
    test_random(300);
    // Hold off until all replies are back, then resume with idling.
    wait_drained();
    idle_pct = 15;
    test_random(300);
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      shadow_key[i] = EmptyKey;
      shadow_val[i] = '0;
    end
    shadow_count = 0;
    shadow_limit = FillLimitReset;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_collisions();
    test_fill_limit();
    write_fill_limit(10'd40);
    test_random(300);
    test_saturation();
    write_fill_limit(10'd512);
    test_random(300);
    wait_drained();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
